// ===== hw/rtl/smx_pkg.sv =====
// Shared opcodes, status codes and types for the stack machine executor.
`default_nettype none
package smx_pkg;

    localparam int DW = 32;

    localparam logic [4:0] A_LIT   = 5'd0;
    localparam logic [4:0] A_DROP  = 5'd1;
    localparam logic [4:0] A_PRINT = 5'd2;
    localparam logic [4:0] A_ADD   = 5'd3;
    localparam logic [4:0] A_SUB   = 5'd4;
    localparam logic [4:0] A_MUL   = 5'd5;
    localparam logic [4:0] A_MOD   = 5'd6;
    localparam logic [4:0] A_DADD  = 5'd7;
    localparam logic [4:0] A_DSUB  = 5'd8;
    localparam logic [4:0] A_DDIV  = 5'd9;
    localparam logic [4:0] A_DMOD  = 5'd10;
    localparam logic [4:0] A_GT    = 5'd11;
    localparam logic [4:0] A_LT    = 5'd12;
    localparam logic [4:0] A_DUP   = 5'd13;
    localparam logic [4:0] A_SWAP  = 5'd14;
    localparam logic [4:0] A_ROT   = 5'd15;
    localparam logic [4:0] A_OVER  = 5'd16;
    localparam logic [4:0] A_OR    = 5'd17;
    localparam logic [4:0] A_AND   = 5'd18;
    localparam logic [4:0] A_NOT   = 5'd19;
    localparam logic [4:0] A_FETCH = 5'd20;
    localparam logic [4:0] A_STORE = 5'd21;
    localparam logic [4:0] A_ALLOC = 5'd22;
    localparam logic [4:0] A_FREE  = 5'd23;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_ALLOC = 3'd5;

    typedef struct packed {
        logic [1:0]          npush;
        logic [2:0][DW-1:0]  val;
    } t_alu_res;

endpackage
`default_nettype wire

// ===== hw/rtl/stack_machine_executor_unit.sv =====
// Top level: sequencer around the data stack memory and the word memory.
//
//  channel  dir  fields (low bit first)
//  s        in   action[4:0], literal[36:5]
//  m        out  status[2:0], shown_value[34:3], shown_valid[35], stack_depth[44:36]
//
// A word is accepted in idle, reads its operands one by one, executes and, when
// it takes the push pass, pushes its results; an underflow goes straight to done.
// Fetch adds a state for the word memory read, and mod, double div and
// double mod wait in the bit-serial divider.
// The stack memory has one read and one write port; operands come one per cycle.
// Reset clears the stack count and heap top; memories are not cleared.
// A finished word waits in the output register while the next word is taken.
`default_nettype none
module stack_machine_executor_unit
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int MEM_WORDS   = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // action, literal
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata    // status, shown_value, shown_valid, stack_depth
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int MAW = $clog2(MEM_WORDS);
    localparam int HW  = $clog2(MEM_WORDS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MEMRD = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic [HW-1:0]       r_heap;
    logic [4:0]          r_act;
    logic [DW-1:0]       r_lit;
    logic [2:0]          r_st;
    logic [DW-1:0]       r_shown;
    logic                r_shv;
    logic [2:0]          r_np, r_k;
    logic                r_capv;
    logic [1:0]          r_capi;
    logic [3:0][DW-1:0]  r_opr;
    logic [2:0][DW-1:0]  r_pv;
    logic [1:0]          r_npush, r_pi;
    logic                r_ov;
    logic [47:0]         r_out;

    logic [DW-1:0]       smem [STACK_DEPTH];
    logic [DW-1:0]       r_sm_q;
    logic [DW-1:0]       wmem [MEM_WORDS];
    logic [DW-1:0]       r_wm_q;

    logic [4:0]          w_act;
    logic [DW-1:0]       w_lit;
    logic [2:0]          w_req, w_pop;
    logic                w_dbl, w_under, w_accept;
    logic [CW-1:0]       w_rd_full;
    logic [SAW-1:0]      w_raddr;
    logic                w_sm_we;
    logic [DW-1:0]       w_wm_sel;
    logic [MAW-1:0]      w_wm_addr;
    logic                w_addr_ok, w_wm_we, w_sz_pos, w_alloc_ok, w_free_ok;
    logic [33:0]         w_sum;
    logic                w_div_start, w_div_busy, w_div_done, w_dzero;
    logic [63:0]         w_dvd, w_dvs, w_quot, w_rem;
    t_alu_res            w_alu;

    assign w_act    = i_s_tdata[4:0];
    assign w_lit    = i_s_tdata[36:5];
    assign w_accept = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        w_dbl = 1'b0;
        case (w_act)
            A_DROP, A_PRINT, A_DUP, A_NOT, A_FETCH, A_ALLOC, A_FREE: w_req = 3'd1;
            A_ADD, A_SUB, A_MUL, A_MOD, A_GT, A_LT, A_OR, A_AND,
            A_SWAP, A_OVER, A_STORE: w_req = 3'd2;
            A_ROT: w_req = 3'd3;
            A_DADD, A_DSUB, A_DDIV, A_DMOD: begin
                w_req = 3'd4;
                w_dbl = 1'b1;
            end
            default: w_req = 3'd0;
        endcase
        if (w_dbl) begin
            w_under = r_cnt < CW'(4);
            w_pop   = w_under ? ((r_cnt >= CW'(2)) ? 3'd2 : 3'd0) : 3'd4;
        end else begin
            w_under = r_cnt < CW'(w_req);
            w_pop   = w_under ? r_cnt[2:0] : w_req;
        end
    end

    assign w_rd_full = r_cnt + CW'(r_np) - CW'(r_k) - CW'(1);
    assign w_raddr   = w_rd_full[SAW-1:0];
    assign w_sm_we   = (r_state == S_PUSH) && (r_pi < r_npush)
                       && (r_cnt != CW'(STACK_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_sm_we) begin
            smem[r_cnt[SAW-1:0]] <= r_pv[r_pi];
        end
        r_sm_q <= smem[w_raddr];
    end

    assign w_wm_sel  = (r_act == A_STORE) ? r_opr[1] : r_opr[0];
    assign w_wm_addr = w_wm_sel[MAW-1:0];
    assign w_addr_ok = w_wm_sel < DW'(MEM_WORDS);
    assign w_wm_we   = (r_state == S_EXEC) && (r_act == A_STORE) && w_addr_ok;

    always_ff @(posedge i_clk) begin
        if (w_wm_we) begin
            wmem[w_wm_addr] <= r_opr[0];
        end
        r_wm_q <= wmem[w_wm_addr];
    end

    assign w_sz_pos   = !r_opr[0][DW-1] && (r_opr[0] != '0);
    assign w_sum      = {2'b00, r_opr[0]} + 34'(r_heap);
    assign w_alloc_ok = w_sz_pos && (w_sum <= 34'(MEM_WORDS));
    assign w_free_ok  = w_sz_pos && ({2'b00, r_opr[0]} <= 34'(r_heap));

    assign w_dzero = (r_act == A_MOD) ? (r_opr[0] == '0) : ({r_opr[0], r_opr[1]} == 64'd0);
    assign w_dvd   = (r_act == A_MOD) ? {{32{r_opr[1][31]}}, r_opr[1]} : {r_opr[2], r_opr[3]};
    assign w_dvs   = (r_act == A_MOD) ? {{32{r_opr[0][31]}}, r_opr[0]} : {r_opr[0], r_opr[1]};
    assign w_div_start = (r_state == S_EXEC) && !w_dzero
                         && ((r_act == A_MOD) || (r_act == A_DDIV) || (r_act == A_DMOD));

    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    smx_alu u_alu (
        .i_action (r_act),
        .i_lit    (r_lit),
        .i_opr    (r_opr),
        .o_res    (w_alu)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_heap  <= '0;
            r_ov    <= 1'b0;
            r_capv  <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act   <= w_act;
                        r_lit   <= w_lit;
                        r_st    <= w_under ? ST_UNDER : ST_OK;
                        r_shown <= '0;
                        r_shv   <= 1'b0;
                        r_cnt   <= r_cnt - CW'(w_pop);
                        r_np    <= w_under ? 3'd0 : w_req;
                        r_k     <= '0;
                        r_pi    <= '0;
                        r_npush <= '0;
                        r_capv  <= 1'b0;
                        if (w_under) begin
                            r_state <= S_DONE;
                        end else if (w_req == 3'd0) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_capv) begin
                        r_opr[r_capi] <= r_sm_q;
                    end
                    if (r_k < r_np) begin
                        r_capv <= 1'b1;
                        r_capi <= r_k[1:0];
                        r_k    <= r_k + 3'd1;
                    end else begin
                        r_capv <= 1'b0;
                        if (!r_capv) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    case (r_act)
                        A_MOD, A_DDIV, A_DMOD: begin
                            if (w_dzero) begin
                                r_st    <= ST_ZERO;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        A_PRINT: begin
                            r_shown <= r_opr[0];
                            r_shv   <= 1'b1;
                            r_state <= S_DONE;
                        end
                        A_FETCH: begin
                            if (w_addr_ok) begin
                                r_state <= S_MEMRD;
                            end else begin
                                r_st    <= ST_ADDR;
                                r_state <= S_DONE;
                            end
                        end
                        A_STORE: begin
                            if (!w_addr_ok) begin
                                r_st <= ST_ADDR;
                            end
                            r_state <= S_DONE;
                        end
                        A_ALLOC: begin
                            if (w_alloc_ok) begin
                                r_heap  <= r_heap + r_opr[0][HW-1:0];
                                r_shown <= DW'(r_heap);
                                r_shv   <= 1'b1;
                                r_pv[0] <= DW'(r_heap);
                                r_npush <= 2'd1;
                                r_state <= S_PUSH;
                            end else begin
                                r_st    <= ST_ALLOC;
                                r_state <= S_DONE;
                            end
                        end
                        A_FREE: begin
                            if (w_free_ok) begin
                                r_heap <= r_heap - r_opr[0][HW-1:0];
                            end else begin
                                r_st <= ST_ALLOC;
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_pv    <= w_alu.val;
                            r_npush <= w_alu.npush;
                            r_state <= S_PUSH;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_act == A_MOD) begin
                            r_pv[0] <= w_rem[31:0];
                            r_npush <= 2'd1;
                        end else if (r_act == A_DDIV) begin
                            r_pv[0] <= w_quot[31:0];
                            r_pv[1] <= w_quot[63:32];
                            r_npush <= 2'd2;
                        end else begin
                            r_pv[0] <= w_rem[31:0];
                            r_pv[1] <= w_rem[63:32];
                            r_npush <= 2'd2;
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_MEMRD: begin
                    r_pv[0] <= r_wm_q;
                    r_npush <= 2'd1;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_pi < r_npush) begin
                        if (r_cnt == CW'(STACK_DEPTH)) begin
                            r_st    <= ST_OVER;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                            r_pi  <= r_pi + 2'd1;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_m_tready) begin
                        r_out   <= {3'd0, 9'(r_cnt), r_shv, r_shown, r_st};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_heap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        34'(r_heap) <= 34'(MEM_WORDS))
        else $error("heap top beyond memory");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_busy || w_div_done))
        else $error("waiting on idle divider");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/smx_div.sv =====
// Iterative signed 64-bit divider, one quotient bit per cycle.
`default_nettype none
module smx_div
    import smx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [63:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [63:0]      o_rem
);

    logic        r_busy, r_fix, r_done, r_nq, r_nr;
    logic [5:0]  r_step;
    logic [63:0] r_rem, r_quo, r_den;
    logic [64:0] w_sh, w_diff;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend[63] ? (64'd0 - i_dividend) : i_dividend;
                r_den  <= i_divisor[63] ? (64'd0 - i_divisor) : i_divisor;
                r_nq   <= i_dividend[63] ^ i_divisor[63];
                r_nr   <= i_dividend[63];
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_step <= r_step + 6'd1;
                if (r_step == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
                r_quo  <= r_nq ? (64'd0 - r_quo) : r_quo;
                r_rem  <= r_nr ? (64'd0 - r_rem) : r_rem;
            end
        end
    end

    assign o_busy = r_busy | r_fix;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_fix)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/smx_alu.sv =====
// Operand shuffles and combinational arithmetic producing the cells to push.
`default_nettype none
module smx_alu
    import smx_pkg::*;
(
    input  wire logic [4:0]          i_action,
    input  wire logic [DW-1:0]       i_lit,
    input  wire logic [3:0][DW-1:0]  i_opr,
    output t_alu_res                 o_res
);

    logic [DW-1:0] w_a, w_b, w_mul;
    logic [63:0]   w_da, w_db, w_dsum, w_ddif;

    assign w_b    = i_opr[0];
    assign w_a    = i_opr[1];
    assign w_mul  = w_a * w_b;
    assign w_db   = {i_opr[0], i_opr[1]};
    assign w_da   = {i_opr[2], i_opr[3]};
    assign w_dsum = w_da + w_db;
    assign w_ddif = w_da - w_db;

    always_comb begin
        o_res.npush = 2'd0;
        o_res.val   = '0;
        case (i_action)
            A_LIT: begin
                o_res.npush = 2'd1; o_res.val[0] = i_lit;
            end
            A_ADD: begin
                o_res.npush = 2'd1; o_res.val[0] = w_a + w_b;
            end
            A_SUB: begin
                o_res.npush = 2'd1; o_res.val[0] = w_a - w_b;
            end
            A_MUL: begin
                o_res.npush = 2'd1; o_res.val[0] = w_mul;
            end
            A_GT: begin
                o_res.npush = 2'd1;
                o_res.val[0] = {31'd0, $signed(w_a) > $signed(w_b)};
            end
            A_LT: begin
                o_res.npush = 2'd1;
                o_res.val[0] = {31'd0, $signed(w_a) < $signed(w_b)};
            end
            A_OR: begin
                o_res.npush = 2'd1;
                o_res.val[0] = {31'd0, (w_a != '0) || (w_b != '0)};
            end
            A_AND: begin
                o_res.npush = 2'd1;
                o_res.val[0] = {31'd0, (w_a != '0) && (w_b != '0)};
            end
            A_NOT: begin
                o_res.npush = 2'd1; o_res.val[0] = {31'd0, w_b == '0};
            end
            A_DUP: begin
                o_res.npush = 2'd2; o_res.val[0] = w_b; o_res.val[1] = w_b;
            end
            A_SWAP: begin
                o_res.npush = 2'd2; o_res.val[0] = w_b; o_res.val[1] = w_a;
            end
            A_ROT: begin
                o_res.npush  = 2'd3;
                o_res.val[0] = i_opr[1];
                o_res.val[1] = i_opr[0];
                o_res.val[2] = i_opr[2];
            end
            A_OVER: begin
                o_res.npush = 2'd3;
                o_res.val[0] = w_a; o_res.val[1] = w_b; o_res.val[2] = w_a;
            end
            A_DADD: begin
                o_res.npush = 2'd2;
                o_res.val[0] = w_dsum[31:0]; o_res.val[1] = w_dsum[63:32];
            end
            A_DSUB: begin
                o_res.npush = 2'd2;
                o_res.val[0] = w_ddif[31:0]; o_res.val[1] = w_ddif[63:32];
            end
            default: begin
                o_res.npush = 2'd0;
            end
        endcase
    end

endmodule
`default_nettype wire
